// ----- rtl/lbps_pkg.sv -----
// Package for the LED blink pattern sequencer.
// Holds widths, mode and register codes, the item and duration structs.
// No dependencies; imported by every module of the block.
package lbps_pkg;

	localparam int LED_COUNT_DEF = 2;
	localparam int PIN_W         = 2;
	localparam int DUR_W         = 16;
	localparam int TIME_W        = 32;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int STAGE_W       = 2;
	localparam int MODE_W        = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_STEADY         = 2'd0,
		MODE_TWO_SHORT      = 2'd1,
		MODE_HALF_DUTY      = 2'd2,
		MODE_TWO_SHORT_STOP = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TWO_SHORT      = 2'd0,
		CFG_HALF_DUTY      = 2'd1,
		CFG_TWO_SHORT_STOP = 2'd2
	} cfg_idx_t;

	localparam logic ACT_TICK     = 1'b0;
	localparam logic ACT_ACTIVATE = 1'b1;

	localparam logic [STAGE_W-1:0] FIRST_STAGE = 2'd0;
	localparam logic [STAGE_W-1:0] LAST_STAGE  = 2'd3;

	typedef struct packed {
		logic              action;
		logic              led_index;
		logic              turn_on;
		logic [MODE_W-1:0] pattern;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] two_short;
		logic [CFG_W-1:0] half_duty;
		logic [CFG_W-1:0] two_short_stop;
	} durations_t;

	typedef struct packed {
		logic  step;
		logic  addressed;
		item_t item;
	} cell_ctrl_t;

	function automatic logic [DUR_W-1:0] stage_duration(
		input mode_t              mode,
		input logic [STAGE_W-1:0] stage,
		input durations_t         durs
	);
		logic [CFG_W-1:0] word;
		logic [DUR_W-1:0] dur;
		case (mode)
			MODE_TWO_SHORT: word = durs.two_short;
			MODE_HALF_DUTY: word = durs.half_duty;
			default:        word = durs.two_short_stop;
		endcase
		case (stage)
			2'd0:    dur = word[DUR_W-1:0];
			2'd1:    dur = word[2*DUR_W-1:DUR_W];
			2'd2:    dur = word[3*DUR_W-1:2*DUR_W];
			default: dur = word[4*DUR_W-1:3*DUR_W];
		endcase
		return dur;
	endfunction

endpackage

// ----- rtl/lbps_if.sv -----
// Channel interfaces for the LED blink pattern sequencer.
// Item channel and result channel, valid/ready with payload.
// Depends on lbps_pkg.
interface lbps_item_if import lbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic              led_index;
	logic              turn_on;
	logic [MODE_W-1:0] pattern;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, action, led_index, turn_on, pattern, now_ms, input ready);
	modport sink   (input valid, action, led_index, turn_on, pattern, now_ms, output ready);
endinterface

interface lbps_result_if import lbps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIN_W-1:0] pin_levels;

	modport source (output valid, pin_levels, input ready);
	modport sink   (input valid, pin_levels, output ready);
endinterface

// ----- rtl/lbps_cfg_regs.sv -----
// Configuration registers of the LED blink pattern sequencer.
// Three 64-bit stage duration words, written through a plain write port.
// Depends on lbps_pkg.
module lbps_cfg_regs import lbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output durations_t           durs
);

	durations_t durs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			durs_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TWO_SHORT:      durs_q.two_short      <= cfg_data;
				CFG_HALF_DUTY:      durs_q.half_duty      <= cfg_data;
				CFG_TWO_SHORT_STOP: durs_q.two_short_stop <= cfg_data;
				default:            durs_q <= durs_q;
			endcase
		end
	end

	assign durs = durs_q;

endmodule

// ----- rtl/lbps_led_cell.sv -----
// Per-LED state and blink update of the LED blink pattern sequencer.
// Holds mode, lit flag, stage and last toggle time of one LED.
// Depends on lbps_pkg.
module lbps_led_cell import lbps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  durations_t durs,
	output logic       lit_next
);

	mode_t              mode_q, mode_d;
	logic               lit_q, lit_d;
	logic [STAGE_W-1:0] stage_q, stage_d;
	logic [TIME_W-1:0]  last_q, last_d;
	logic [DUR_W-1:0]   dur;
	logic [TIME_W-1:0]  due;
	logic               expire;

	always_comb begin
		dur    = stage_duration(mode_q, stage_q, durs);
		due    = last_q + TIME_W'(dur);
		expire = (mode_q != MODE_STEADY) && (ctrl.item.now_ms >= due);
		mode_d  = mode_q;
		lit_d   = lit_q;
		stage_d = stage_q;
		last_d  = last_q;
		if (ctrl.step) begin
			if (ctrl.item.action == ACT_ACTIVATE) begin
				if (ctrl.addressed) begin
					if (!ctrl.item.turn_on) begin
						mode_d = MODE_STEADY;
						lit_d  = 1'b0;
					end else if (mode_t'(ctrl.item.pattern) == MODE_STEADY) begin
						mode_d = MODE_STEADY;
						lit_d  = 1'b1;
					end else begin
						mode_d  = mode_t'(ctrl.item.pattern);
						stage_d = FIRST_STAGE;
						last_d  = '0;
						lit_d   = 1'b1;
					end
				end
			end else if (expire) begin
				lit_d  = ~lit_q;
				last_d = ctrl.item.now_ms;
				if (stage_q == LAST_STAGE) begin
					stage_d = FIRST_STAGE;
					if (mode_q == MODE_TWO_SHORT_STOP) begin
						mode_d = MODE_STEADY;
						lit_d  = 1'b0;
					end
				end else begin
					stage_d = stage_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STEADY;
			lit_q   <= 1'b0;
			stage_q <= FIRST_STAGE;
			last_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			lit_q   <= lit_d;
			stage_q <= stage_d;
			last_q  <= last_d;
		end
	end

	assign lit_next = lit_d;

endmodule

// ----- rtl/led_blink_pattern_sequencer_top.sv -----
// Top level of the LED blink pattern sequencer.
// Input register, one state cell per LED, result register, config registers.
// Depends on lbps_pkg, lbps_if, lbps_cfg_regs and lbps_led_cell.
//
// Usage:
//   items   : valid/ready channel. action 0 is a time tick carrying now_ms,
//             action 1 sets LED led_index off, steady on or to a blink pattern.
//   results : valid/ready channel, one pin_levels word per item, active low.
//   cfg_*   : write port for the three 64-bit stage duration words; write
//             only while no item is in flight.
// An item is captured in the input register; when it advances, the LED cells
// update from it and the pin levels land in the result register together.
// Throughput is one item per cycle while results are not stalled; every LED
// updates in parallel with one add and one compare on its last toggle time.
// Reset clears all LEDs to steady and dark, zeroes stages, toggle times and
// duration words, and empties both registers.
// When the receiver stalls, the result holds and one further item is taken
// into the input register; after that items ready drops until the result
// transfer completes.
module led_blink_pattern_sequencer_top import lbps_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lbps_item_if.sink            items,
	lbps_result_if.source        results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	item_t            item_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic [PIN_W-1:0] pins_q;
	logic [PIN_W-1:0] pins_d;
	logic             advance;
	logic             take;
	logic [LED_COUNT-1:0] lit_next;
	durations_t       durs;

	assign advance     = !out_valid_q || results.ready;
	assign items.ready = !valid_s1 || advance;
	assign take        = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action    <= items.action;
			item_s1.led_index <= items.led_index;
			item_s1.turn_on   <= items.turn_on;
			item_s1.pattern   <= items.pattern;
			item_s1.now_ms    <= items.now_ms;
		end
	end

	lbps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.durs      (durs)
	);

	for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
		cell_ctrl_t ctrl;
		assign ctrl.step      = valid_s1 && advance;
		assign ctrl.addressed = (int'(item_s1.led_index) == i);
		assign ctrl.item      = item_s1;

		lbps_led_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.durs     (durs),
			.lit_next (lit_next[i])
		);
	end

	for (genvar p = 0; p < PIN_W; p++) begin : g_pin
		if (p < LED_COUNT) begin : g_present
			assign pins_d[p] = ~lit_next[p];
		end else begin : g_absent
			assign pins_d[p] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pins_q <= pins_d;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.pin_levels = pins_q;

endmodule

// ----- rtl/lbps_checker.sv -----
// Port-level checker for the LED blink pattern sequencer.
// Watches the item and result channels of the top level; bound below.
// Depends on lbps_pkg.
module lbps_checker import lbps_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIN_W-1:0] pin_levels
);

	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> ##2 out_valid)
		else $error("no result two cycles after item transfer");

	a_absent_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (LED_COUNT > 1) || pin_levels[1])
		else $error("absent LED shows lit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pin_levels))
		else $error("stalled result changed");

endmodule

bind led_blink_pattern_sequencer_top lbps_checker #(.LED_COUNT(LED_COUNT)) u_lbps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.pin_levels (results.pin_levels)
);

// ----- tb/lbps_pin_compare.sv -----
// Scoreboard for the LED blink pattern sequencer: predicts pin levels per item.
// Watches the item, result and register write ports; counts mismatches.
// Depends on lbps_pkg and lbps_if.
module lbps_pin_compare import lbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lbps_item_if                 items,
	lbps_result_if               results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending
);

	logic [CFG_W-1:0]   dur_two_short;
	logic [CFG_W-1:0]   dur_half_duty;
	logic [CFG_W-1:0]   dur_two_short_stop;
	mode_t              led_mode_q [PIN_W];
	logic               led_lit_q  [PIN_W];
	logic [STAGE_W-1:0] stage_q    [PIN_W];
	logic [TIME_W-1:0]  last_q     [PIN_W];
	logic [PIN_W-1:0]   pins_q[$];

	function automatic logic [DUR_W-1:0] stage_len(input mode_t m, input logic [STAGE_W-1:0] s);
		logic [CFG_W-1:0] w;
		case (m)
			MODE_TWO_SHORT: w = dur_two_short;
			MODE_HALF_DUTY: w = dur_half_duty;
			default:        w = dur_two_short_stop;
		endcase
		return w[DUR_W*s +: DUR_W];
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t              it;
		logic [TIME_W-1:0]  due;
		logic [PIN_W-1:0]   pins;
		logic [PIN_W-1:0]   want;
		if (!arst_n) begin
			dur_two_short      = '0;
			dur_half_duty      = '0;
			dur_two_short_stop = '0;
			for (int i = 0; i < PIN_W; i++) begin
				led_mode_q[i] = MODE_STEADY;
				led_lit_q[i]  = 1'b0;
				stage_q[i]    = FIRST_STAGE;
				last_q[i]     = '0;
			end
			pins_q.delete();
			mismatches = 0;
			pending   <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (pins_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result pin_levels=%b", results.pin_levels));
				end else begin
					want = pins_q.pop_front();
					if (results.pin_levels !== want) begin
						note_mismatch($sformatf("pin_levels mismatch: expected %b, got %b",
							want, results.pin_levels));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TWO_SHORT:      dur_two_short      = cfg_data;
					CFG_HALF_DUTY:      dur_half_duty      = cfg_data;
					CFG_TWO_SHORT_STOP: dur_two_short_stop = cfg_data;
					default: ;
				endcase
			end
			if (items.valid && items.ready) begin
				it.action    = items.action;
				it.led_index = items.led_index;
				it.turn_on   = items.turn_on;
				it.pattern   = items.pattern;
				it.now_ms    = items.now_ms;
				if (it.action == ACT_ACTIVATE) begin
					if (!it.turn_on) begin
						led_mode_q[it.led_index] = MODE_STEADY;
						led_lit_q[it.led_index]  = 1'b0;
					end else if (mode_t'(it.pattern) == MODE_STEADY) begin
						led_mode_q[it.led_index] = MODE_STEADY;
						led_lit_q[it.led_index]  = 1'b1;
					end else begin
						led_mode_q[it.led_index] = mode_t'(it.pattern);
						stage_q[it.led_index]    = FIRST_STAGE;
						last_q[it.led_index]     = '0;
						led_lit_q[it.led_index]  = 1'b1;
					end
				end else begin
					for (int i = 0; i < PIN_W; i++) begin
						if (led_mode_q[i] != MODE_STEADY) begin
							due = last_q[i] + stage_len(led_mode_q[i], stage_q[i]);
							if (it.now_ms >= due) begin
								led_lit_q[i] = ~led_lit_q[i];
								last_q[i]    = it.now_ms;
								if (stage_q[i] == LAST_STAGE) begin
									stage_q[i] = FIRST_STAGE;
									if (led_mode_q[i] == MODE_TWO_SHORT_STOP) begin
										led_mode_q[i] = MODE_STEADY;
										led_lit_q[i]  = 1'b0;
									end
								end else begin
									stage_q[i] = stage_q[i] + 1'b1;
								end
							end
						end
					end
				end
				for (int i = 0; i < PIN_W; i++) begin
					pins[i] = ~led_lit_q[i];
				end
				pins_q.push_back(pins);
			end
			pending <= pins_q.size();
		end
	end

endmodule

// ----- tb/led_blink_pattern_sequencer_top_tb.sv -----
// Testbench top for the LED blink pattern sequencer: clock, reset, stimulus, verdict.
// Drives items and duration registers, stalls the result channel at random.
// Depends on lbps_pkg, lbps_if, the block and lbps_pin_compare.
module led_blink_pattern_sequencer_top_tb;
	import lbps_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 145;
	localparam int HOLD_CYCLES  = 60;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   send_idle = 13;
	int                   recv_idle = 77;
	int                   hold_req  = 0;
	int                   hold_done = 0;
	int                   cycles    = 0;
	int                   mismatches;
	int                   pending;
	logic [TIME_W-1:0]    clock_ms  = '0;

	lbps_item_if   items_ch();
	lbps_result_if results_ch();

	led_blink_pattern_sequencer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lbps_pin_compare u_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items_ch),
		.results    (results_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("led_blink_pattern_sequencer_top verification failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		results_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req != hold_done) begin
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = hold_req;
			end else begin
				results_ch.ready <= ($urandom_range(99) >= recv_idle);
				@(posedge clk);
			end
		end
	end

	function automatic item_t mk_tick(input logic [TIME_W-1:0] now);
		item_t it;
		it.action    = ACT_TICK;
		it.led_index = 1'($urandom_range(1));
		it.turn_on   = 1'($urandom_range(1));
		it.pattern   = MODE_W'($urandom_range(3));
		it.now_ms    = now;
		return it;
	endfunction

	function automatic item_t mk_act(input logic idx, input logic on, input mode_t pat);
		item_t it;
		it.action    = ACT_ACTIVATE;
		it.led_index = idx;
		it.turn_on   = on;
		it.pattern   = pat;
		it.now_ms    = $urandom;
		return it;
	endfunction

	function automatic logic [CFG_W-1:0] short_durations();
		logic [CFG_W-1:0] w;
		for (int k = 0; k < 4; k++) begin
			w[k*DUR_W +: DUR_W] = DUR_W'($urandom_range(0, 15));
		end
		return w;
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid     <= 1'b1;
		items_ch.action    <= it.action;
		items_ch.led_index <= it.led_index;
		items_ch.turn_on   <= it.turn_on;
		items_ch.pattern   <= it.pattern;
		items_ch.now_ms    <= it.now_ms;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
	endtask

	task automatic set_durations(input logic [CFG_W-1:0] w_two_short,
			input logic [CFG_W-1:0] w_half, input logic [CFG_W-1:0] w_stop);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TWO_SHORT;
		cfg_data  <= w_two_short;
		@(posedge clk);
		cfg_index <= CFG_HALF_DUTY;
		cfg_data  <= w_half;
		@(posedge clk);
		cfg_index <= CFG_TWO_SHORT_STOP;
		cfg_data  <= w_stop;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random();
		int r;
		if ($urandom_range(99) < 25) begin
			send_item(mk_act(1'($urandom_range(1)), ($urandom_range(99) < 85),
				mode_t'($urandom_range(3))));
		end else begin
			r = $urandom_range(99);
			if (r < 80) begin
				clock_ms = clock_ms + $urandom_range(0, 12);
			end else if (r < 88) begin
				clock_ms = $urandom_range(0, 40);
			end else if (r < 94) begin
				clock_ms = clock_ms + $urandom_range(0, 70000);
			end else if (r < 97) begin
				clock_ms = $urandom;
			end else begin
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
			end
			send_item(mk_tick(clock_ms));
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		items_ch.valid     <= 1'b0;
		items_ch.action    <= ACT_TICK;
		items_ch.led_index <= 1'b0;
		items_ch.turn_on   <= 1'b0;
		items_ch.pattern   <= MODE_STEADY;
		items_ch.now_ms    <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_TWO_SHORT;
		cfg_data           <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_durations(64'h0004_0003_0002_0001, 64'h0005_0005_0005_0005,
			64'h0002_0001_0002_0001);
		send_item(mk_tick(32'd0));
		send_item(mk_act(1'b0, 1'b1, MODE_STEADY));
		send_item(mk_act(1'b1, 1'b1, MODE_TWO_SHORT_STOP));
		send_item(mk_act(1'b0, 1'b1, MODE_TWO_SHORT));
		send_item(mk_tick(32'd1));
		send_item(mk_tick(32'd2));
		send_item(mk_tick(32'd3));
		send_item(mk_tick(32'd4));
		send_item(mk_tick(32'd6));
		send_item(mk_tick(32'd8));
		send_item(mk_tick(32'd10));
		send_item(mk_tick(32'd13));
		send_item(mk_act(1'b1, 1'b0, MODE_HALF_DUTY));
		send_item(mk_act(1'b1, 1'b1, MODE_HALF_DUTY));
		send_item(mk_tick(32'hFFFF_FFFF));
		send_item(mk_tick(32'd0));
		send_item(mk_tick(32'd4));
		send_item(mk_act(1'b0, 1'b1, MODE_STEADY));
		send_item(mk_act(1'b1, 1'b0, MODE_STEADY));
		send_item(mk_act(1'b0, 1'b0, MODE_TWO_SHORT));
		send_item(mk_tick(32'h8000_0000));
		items_ch.valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: set_durations(short_durations(), short_durations(), short_durations());
				1: begin
					send_idle = 77;
					recv_idle = 13;
					set_durations({CFG_W{1'b1}}, '0, short_durations());
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					set_durations(short_durations(), {$urandom, $urandom}, short_durations());
					hold_req++;
				end
			endcase
			clock_ms = '0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random();
			end
			items_ch.valid <= 1'b0;
			drain();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("led_blink_pattern_sequencer_top verification clean");
		end else begin
			$display("led_blink_pattern_sequencer_top verification failed");
		end
		$finish;
	end

endmodule
